// File: hw/rtl/fpfe_pkg.sv
// ============================================================================
// fpfe_pkg - shared types and constants for the framed packet field extractor
// Transaction payloads, configuration register indexes and packet constants.
// ============================================================================
package fpfe_pkg;

    // Packet layout: two header bytes, one length byte, then payload.
    localparam int PayloadBase = 3;
    localparam int MaxTotal    = 259;
    localparam int NumFields   = 5;
    localparam int IdxW        = 9;
    localparam int CfgIndexW   = 4;
    localparam int CfgDataW    = 9;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CfgHeaderFirst  = 4'd0;
    localparam logic [CfgIndexW-1:0] CfgHeaderSecond = 4'd1;
    localparam logic [CfgIndexW-1:0] CfgMinBytes     = 4'd2;
    localparam logic [CfgIndexW-1:0] CfgThrottleOff  = 4'd3;
    localparam logic [CfgIndexW-1:0] CfgSpeedLowOff  = 4'd4;
    localparam logic [CfgIndexW-1:0] CfgSpeedHighOff = 4'd5;
    localparam logic [CfgIndexW-1:0] CfgAccelOff     = 4'd6;
    localparam logic [CfgIndexW-1:0] CfgBrakeOff     = 4'd7;

    // Captured field slots.
    localparam int FldThrottle  = 0;
    localparam int FldSpeedLow  = 1;
    localparam int FldSpeedHigh = 2;
    localparam int FldAccel     = 3;
    localparam int FldBrake     = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic              packet_ok;
        logic [7:0]        throttle;
        logic [15:0]       speed;
        logic signed [7:0] accel_tenths;
        logic [7:0]        brake;
    } t_out;

    typedef struct packed {
        logic [7:0]                  header_first;
        logic [7:0]                  header_second;
        logic [8:0]                  min_packet_bytes;
        logic [NumFields-1:0][7:0]   field_offset;
    } t_cfg;

endpackage

// File: hw/rtl/fpfe_cfg_regs.sv
// ============================================================================
// fpfe_cfg_regs - configuration register file
// Holds header values, minimum length and the five payload field offsets.
// ============================================================================
module fpfe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpfe_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [fpfe_pkg::CfgDataW-1:0]  i_cfg_data,
    output fpfe_pkg::t_cfg                o_cfg
);
    import fpfe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CfgHeaderFirst:  n_cfg.header_first  = i_cfg_data[7:0];
                CfgHeaderSecond: n_cfg.header_second = i_cfg_data[7:0];
                CfgMinBytes:     n_cfg.min_packet_bytes = i_cfg_data;
                CfgThrottleOff:  n_cfg.field_offset[FldThrottle]  = i_cfg_data[7:0];
                CfgSpeedLowOff:  n_cfg.field_offset[FldSpeedLow]  = i_cfg_data[7:0];
                CfgSpeedHighOff: n_cfg.field_offset[FldSpeedHigh] = i_cfg_data[7:0];
                CfgAccelOff:     n_cfg.field_offset[FldAccel]     = i_cfg_data[7:0];
                CfgBrakeOff:     n_cfg.field_offset[FldBrake]     = i_cfg_data[7:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first     <= 8'd0;
            r_cfg.header_second    <= 8'd0;
            r_cfg.min_packet_bytes <= 9'd9;
            for (int i = 0; i < NumFields; i++) begin
                r_cfg.field_offset[i] <= 8'(i);
            end
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/framed_packet_field_extractor.sv
// ============================================================================
// framed_packet_field_extractor - byte-stream packet parser
// Checks header, length and 8-bit sum of a framed packet and extracts the
// throttle, speed, acceleration and brake fields from its payload.
// ============================================================================
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ---------------------------
//  in       sink       i_in_valid / o_in_ready   t_in  (data_byte, final_byte)
//  out      source     o_out_valid / i_out_ready t_out (packet_ok + fields)
//  cfg      sink       i_cfg_we (no wait)        index 0..7, 9-bit data
//
//  One byte transaction per cycle unless stalled. Packet state updates in the
//  accept cycle, which also loads the final byte's result into the output register.
//  The input stalls only while a result sits in the output register and the
//  downstream side holds i_out_ready low.
//  Synchronous active-low reset clears packet state and loads register defaults.
//
module framed_packet_field_extractor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fpfe_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fpfe_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [fpfe_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [fpfe_pkg::CfgDataW-1:0]  i_cfg_data
);
    import fpfe_pkg::*;

    t_cfg cfg;

    fpfe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Packet state
    logic [IdxW-1:0]           r_byte_index, n_byte_index;
    logic                      r_header_match, n_header_match;
    logic [7:0]                r_length_byte, n_length_byte;
    logic [7:0]                r_running_sum, n_running_sum;
    logic                      r_overlong, n_overlong;
    logic [NumFields-1:0][7:0] r_fields, n_fields;

    // Output register
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    logic            in_fire;
    logic            out_fire;
    logic [7:0]      b;
    logic            in_payload;
    logic [7:0]      rel;
    logic [IdxW-1:0] total;
    logic [IdxW-1:0] expected;
    logic            ok;

    // Hold the input while an untaken result fills the output register.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign b          = i_in_data.data_byte;

    assign in_payload = (r_byte_index >= IdxW'(PayloadBase))
                     && (r_byte_index <  IdxW'(MaxTotal));
    assign rel        = 8'(r_byte_index - IdxW'(PayloadBase));
    assign total      = r_byte_index + IdxW'(1);

    always_comb begin
        // Fold the current byte into header, length, capture and overlong state.
        n_header_match = r_header_match;
        n_length_byte  = r_length_byte;
        n_fields       = r_fields;
        n_overlong     = r_overlong || (r_byte_index >= IdxW'(MaxTotal));
        if (r_byte_index == IdxW'(0)) begin
            n_header_match = (b == cfg.header_first);
        end
        if (r_byte_index == IdxW'(1)) begin
            n_header_match = r_header_match && (b == cfg.header_second);
        end
        if (r_byte_index == IdxW'(2)) begin
            n_length_byte = b;
        end
        for (int i = 0; i < NumFields; i++) begin
            if (in_payload && (rel == cfg.field_offset[i])) begin
                n_fields[i] = b;
            end
        end

        // Length the header promises, taken before packet state is cleared.
        expected = IdxW'(PayloadBase) + IdxW'(n_length_byte) + IdxW'(1);

        // The checksum byte itself is excluded from the sum.
        ok = !n_overlong
          && (total >= cfg.min_packet_bytes)
          && n_header_match
          && (total == expected)
          && (r_running_sum == b);

        n_out              = '0;
        n_out.packet_ok    = ok;
        if (ok) begin
            n_out.throttle     = n_fields[FldThrottle];
            n_out.speed        = {n_fields[FldSpeedHigh], n_fields[FldSpeedLow]};
            n_out.accel_tenths = n_fields[FldAccel];
            n_out.brake        = n_fields[FldBrake];
        end

        n_running_sum = r_running_sum + b;
        n_byte_index  = (r_byte_index < IdxW'(MaxTotal)) ? r_byte_index + IdxW'(1)
                                                          : r_byte_index;
        n_out_valid   = r_out_valid && !i_out_ready;

        if (in_fire && i_in_data.final_byte) begin
            // End of packet: issue the result and clear packet state.
            n_out_valid    = 1'b1;
            n_byte_index   = '0;
            n_header_match = 1'b1;
            n_length_byte  = '0;
            n_running_sum  = '0;
            n_overlong     = 1'b0;
            n_fields       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_header_match <= 1'b1;
            r_length_byte  <= '0;
            r_running_sum  <= '0;
            r_overlong     <= 1'b0;
            r_fields       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                r_byte_index   <= n_byte_index;
                r_header_match <= n_header_match;
                r_length_byte  <= n_length_byte;
                r_running_sum  <= n_running_sum;
                r_overlong     <= n_overlong;
                r_fields       <= n_fields;
            end
        end
    end

    // Result payload loads only with a final byte.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.final_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.final_byte) |=> o_out_valid)
        else $error("final byte did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in_data.final_byte && out_fire) |=> !o_out_valid)
        else $error("result appeared without a final byte");

    a_bad_packet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.packet_ok) |->
        (o_out_data.throttle == 8'd0 && o_out_data.speed == 16'd0
         && o_out_data.accel_tenths == 8'sd0 && o_out_data.brake == 8'd0))
        else $error("invalid packet carries nonzero fields");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= IdxW'(MaxTotal))
        else $error("byte index past saturation");

    a_overlong_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overlong |-> (r_byte_index == IdxW'(MaxTotal)))
        else $error("overlong flag without saturated index");

endmodule

// File: dv/tb_top.sv
// ============================================================================
// tb_top - testbench for the framed packet field extractor
// Streams framed byte packets into the block under random idling on both
// channels, predicts every frame result in a scoreboard and compares each
// result field by field against the oldest prediction.
// ============================================================================
module tb_top;
    import fpfe_pkg::*;

    localparam int ClkPeriod    = 10;
    localparam int ResetCycles  = 6;
    localparam int ByteTarget   = 1550;   // stop launching frames past this
    localparam int QuietTail    = 1300;   // no idling once this many bytes went in
    localparam int PhaseBytes   = 150;    // bytes per register setting
    localparam int QuietLimit   = 2000;   // cycles without any transaction
    localparam int SettleCycles = 4;      // output register latency plus margin
    localparam int ReportLimit  = 10;
    localparam int CfgDataMax   = (1 << CfgDataW) - 1;
    localparam int CfgIndexMax  = (1 << CfgIndexW) - 1;
    localparam logic [CfgIndexW-1:0] CfgIdxFirstUnused = CfgBrakeOff + 1'b1;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the register file and the per-frame state.
    // absorb_byte() advances the frame on every accepted input transaction and
    // queues a prediction on the final byte; check_frame() retires one.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        t_cfg        cfg;
        int unsigned byte_index;
        bit          header_match;
        logic [7:0]  length_byte;
        logic [7:0]  running_sum;
        bit          overlong;
        logic [7:0]  captured [NumFields];
        t_out        expected_frames [$];
        int          failures;

        function new();
            int i;
            cfg.header_first     = '0;
            cfg.header_second    = '0;
            cfg.min_packet_bytes = 9'd9;
            for (i = 0; i < NumFields; i++) cfg.field_offset[i] = 8'(i);
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_index   = 0;
            header_match = 1'b1;
            length_byte  = '0;
            running_sum  = '0;
            overlong     = 1'b0;
            foreach (captured[i]) captured[i] = '0;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CfgHeaderFirst:  cfg.header_first                = data[7:0];
                CfgHeaderSecond: cfg.header_second               = data[7:0];
                CfgMinBytes:     cfg.min_packet_bytes            = data[8:0];
                CfgThrottleOff:  cfg.field_offset[FldThrottle]   = data[7:0];
                CfgSpeedLowOff:  cfg.field_offset[FldSpeedLow]   = data[7:0];
                CfgSpeedHighOff: cfg.field_offset[FldSpeedHigh]  = data[7:0];
                CfgAccelOff:     cfg.field_offset[FldAccel]      = data[7:0];
                CfgBrakeOff:     cfg.field_offset[FldBrake]      = data[7:0];
                default: ;
            endcase
        endfunction

        function void absorb_byte(t_in item);
            int unsigned pos;
            int unsigned total;
            bit          ok;
            t_out        res;
            int          i;
            pos = byte_index;
            if (pos == 0) begin
                header_match = (item.data_byte == cfg.header_first);
            end else if (pos == 1) begin
                header_match = header_match && (item.data_byte == cfg.header_second);
            end else if (pos == 2) begin
                length_byte = item.data_byte;
            end
            if (pos >= PayloadBase && pos < MaxTotal) begin
                for (i = 0; i < NumFields; i++) begin
                    if (pos - PayloadBase == cfg.field_offset[i]) captured[i] = item.data_byte;
                end
            end
            if (pos >= MaxTotal) overlong = 1'b1;
            if (!item.final_byte) begin
                running_sum += item.data_byte;
                if (byte_index < MaxTotal) byte_index++;
                return;
            end
            total = pos + 1;
            ok = !overlong && total >= cfg.min_packet_bytes && header_match
                && total == PayloadBase + length_byte + 1
                && running_sum == item.data_byte;
            res = '0;
            if (ok) begin
                res.packet_ok    = 1'b1;
                res.throttle     = captured[FldThrottle];
                res.speed        = {captured[FldSpeedHigh], captured[FldSpeedLow]};
                res.accel_tenths = captured[FldAccel];
                res.brake        = captured[FldBrake];
            end
            expected_frames.push_back(res);
            clear_frame();
        endfunction

        function void check_frame(t_out got);
            t_out want;
            if (expected_frames.size() == 0) begin
                failures++;
                if (failures <= ReportLimit) begin
                    $display("unexpected result: ok=%0b thr=%h spd=%h acc=%h brk=%h",
                             got.packet_ok, got.throttle, got.speed, got.accel_tenths,
                             got.brake);
                end
                return;
            end
            want = expected_frames.pop_front();
            if (got.packet_ok !== want.packet_ok || got.throttle !== want.throttle
                || got.speed !== want.speed || got.accel_tenths !== want.accel_tenths
                || got.brake !== want.brake) begin
                failures++;
                if (failures <= ReportLimit) begin
                    $display("result mismatch: exp ok=%0b thr=%h spd=%h acc=%h brk=%h",
                             want.packet_ok, want.throttle, want.speed, want.accel_tenths,
                             want.brake);
                    $display("                 got ok=%0b thr=%h spd=%h acc=%h brk=%h",
                             got.packet_ok, got.throttle, got.speed, got.accel_tenths,
                             got.brake);
                end
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every block input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data  = '0;

    bit                   idle_en    = 1'b1;   // random idling on both channels
    int                   bytes_sent = 0;
    logic [7:0]           frame_q [$];         // frame under construction
    frame_scoreboard      sb = new();

    framed_packet_field_extractor u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    // Monitor: sample both channels at the rising edge. Retire results first,
    // so a result can never be matched against a byte of the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_frame(out_data);
            if (in_valid && in_ready) sb.absorb_byte(in_data);
        end
    end

    // Receiver: drop ready at random while idling is on,
    // otherwise hold it high.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else if (idle_en && out_ready && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                hold = $urandom_range(0, 7);
            end else begin
                out_ready <= 1'b1;
                hold = $urandom_range(0, 5);
            end
        end
    end

    // Watchdog: end the run once no transaction has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Inputs change only at the falling edge.
    // ------------------------------------------------------------------------

    // Present one byte, optionally after an idle burst, and hold it until
    // the rising edge that accepts it.
    task automatic send_byte(input logic [7:0] value, input logic last_byte);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'{data_byte: value, final_byte: last_byte};
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Send the staged frame; its last byte carries the final flag.
    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Append the 8-bit wrapping sum of the staged bytes as the checksum.
    function automatic void append_sum();
        logic [7:0] sum;
        sum = '0;
        foreach (frame_q[i]) sum += frame_q[i];
        frame_q.push_back(sum);
    endfunction

    // Stage header, length byte and random payload; no checksum yet.
    task automatic build_frame(input logic [7:0] len_byte, input int payload_count);
        frame_q.push_back(sb.cfg.header_first);
        frame_q.push_back(sb.cfg.header_second);
        frame_q.push_back(len_byte);
        repeat (payload_count) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed frames with random content; the rest break the
    // header, the length, the checksum, cut the frame short, or are noise.
    task automatic send_random_frame();
        int         kind;
        int         len;
        int         keep;
        logic [7:0] mask;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 39) == 0) ? $urandom_range(25, 255) : $urandom_range(0, 24);
        mask = 8'($urandom_range(1, 255));
        build_frame(8'(len), len);
        if (kind >= 70 && kind < 76) begin
            frame_q[$urandom_range(0, 1)] ^= mask;
        end else if (kind >= 76 && kind < 82) begin
            frame_q[2] += mask;
        end else if (kind >= 82 && kind < 88) begin
            keep = $urandom_range(0, frame_q.size() - 1);
            while (frame_q.size() > keep) void'(frame_q.pop_back());
        end else if (kind >= 88 && kind < 94) begin
            frame_q.delete();
            repeat ($urandom_range(0, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        append_sum();
        if (kind >= 94) frame_q[$] ^= mask;
        send_frame();
    endtask

    // Drop valid, hold off until every predicted result has been retired,
    // then let the output register settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Program every register for one phase. Minimum cycles through its
    // extremes; offsets are small and packet-sized, extreme, or all equal.
    // Bit 8 is set at random on the 8-bit registers to check truncation.
    task automatic program_phase(input int phase);
        logic [CfgDataW-1:0] min_val;
        logic [CfgDataW-1:0] offs [NumFields];
        int                  common;
        int                  i;
        case (phase % 6)
            0:       min_val = 9'd9;
            1:       min_val = '0;
            2:       min_val = 9'(MaxTotal);
            3:       min_val = 9'($urandom_range(MaxTotal + 1, CfgDataMax));
            4:       min_val = 9'($urandom_range(0, 30));
            default: min_val = 9'($urandom_range(0, 12));
        endcase
        common = $urandom_range(0, 8);
        for (i = 0; i < NumFields; i++) begin
            case (phase % 3)
                0: offs[i] = 9'($urandom_range(0, 12));
                1: begin
                    case ($urandom_range(0, 3))
                        0:       offs[i] = '0;
                        1:       offs[i] = 9'd254;
                        2:       offs[i] = 9'd255;
                        default: offs[i] = 9'($urandom_range(0, 255));
                    endcase
                end
                default: offs[i] = 9'(common);
            endcase
            offs[i][8] = 1'($urandom_range(0, 1));
        end
        write_reg(CfgHeaderFirst, 9'($urandom_range(0, CfgDataMax)));
        write_reg(CfgHeaderSecond, 9'($urandom_range(0, CfgDataMax)));
        write_reg(CfgMinBytes, min_val);
        write_reg(CfgThrottleOff, offs[FldThrottle]);
        write_reg(CfgSpeedLowOff, offs[FldSpeedLow]);
        write_reg(CfgSpeedHighOff, offs[FldSpeedHigh]);
        write_reg(CfgAccelOff, offs[FldAccel]);
        write_reg(CfgBrakeOff, offs[FldBrake]);
        // Unmapped index: the block must ignore the write.
        write_reg(CfgIndexW'($urandom_range(CfgIdxFirstUnused, CfgIndexMax)),
                  9'($urandom_range(0, CfgDataMax)));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int phase_start;

        // Hold reset for the first cycles, then release it once.
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames on the reset register values.
        // Minimum-length valid frame with extreme field values, including
        // the most negative acceleration.
        build_frame(8'd5, 0);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h80);
        frame_q.push_back(8'h7F);
        append_sum();
        send_frame();
        // A frame that is only its checksum byte.
        frame_q.push_back(8'hFF);
        send_frame();
        // Frame too short to carry a length byte before the checksum.
        frame_q.push_back(sb.cfg.header_first);
        frame_q.push_back(sb.cfg.header_second);
        append_sum();
        send_frame();
        // Otherwise valid frame with a bad checksum.
        build_frame(8'd5, 5);
        append_sum();
        frame_q[$] ^= 8'h01;
        send_frame();

        // Random phases: drain, reprogram, then stream frames.
        phase = 0;
        while (bytes_sent < ByteTarget) begin
            drain();
            program_phase(phase);
            idle_en = (phase % 3 != 2) && (bytes_sent < QuietTail);
            // Longest legal frame, so offsets up to the checksum get hit.
            if (phase == 1) begin
                build_frame(8'd255, 255);
                append_sum();
                send_frame();
            end
            // Frame past the longest legal size: the index saturates.
            if (phase == 2) begin
                build_frame(8'd255, 256 + $urandom_range(0, 6));
                append_sum();
                send_frame();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PhaseBytes && bytes_sent < ByteTarget) begin
                if (bytes_sent >= QuietTail) idle_en = 1'b0;
                send_random_frame();
            end
            phase++;
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fpfe_pkg.sv
hw/rtl/fpfe_cfg_regs.sv
hw/rtl/framed_packet_field_extractor.sv
dv/tb_top.sv
